// ----- rtl/core/wicg_pkg.sv -----
// Shared types, codes and register indexes for the wake input debounce cooldown gate.
package wicg_pkg;

    localparam int unsigned TimeW   = 32;
    localparam int unsigned CfgW    = 16;
    localparam int unsigned CfgAddrW = 2;
    localparam int unsigned InDataW  = 8;
    localparam int unsigned OutDataW = 120;

    localparam logic [CfgAddrW-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CfgAddrW-1:0] REG_COOLDOWN = 2'd1;
    localparam logic [CfgAddrW-1:0] REG_WINDOW   = 2'd2;

    localparam logic [CfgW-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CfgW-1:0] COOLDOWN_RST = 16'd3000;
    localparam logic [CfgW-1:0] WINDOW_RST   = 16'd10000;

    typedef enum logic [2:0] {
        CODE_NONE     = 3'd0,
        CODE_DEBOUNCE = 3'd1,
        CODE_COOLDOWN = 3'd2,
        CODE_FACE     = 3'd3,
        CODE_RECENT   = 3'd4,
        CODE_DOOR     = 3'd5,
        CODE_ACCEPT   = 3'd6
    } result_code_t;

    typedef struct packed {
        logic door_closed;
        logic garage_recent;
        logic face_window_on;
        logic pin_low;
        logic edge_seen;
    } tick_item_t;

    typedef struct packed {
        logic [CfgW-1:0] debounce_ms;
        logic [CfgW-1:0] cooldown_ms;
        logic [CfgW-1:0] wake_window_ms;
    } cfg_t;

    typedef struct packed {
        logic [TimeW-1:0] tick_clock;
        logic [TimeW-1:0] edge_time;
        logic [TimeW-1:0] wake_time;
        logic [TimeW-1:0] event_stamp;
        logic             debounce_armed;
        logic [TimeW-1:0] request_counter;
        logic [TimeW-1:0] accept_counter;
        result_code_t     last_code;
    } gate_state_t;

    typedef struct packed {
        logic [TimeW-1:0] event_time;
        logic [TimeW-1:0] accepted_total;
        logic [TimeW-1:0] requests_total;
        result_code_t     result_code;
        logic [CfgW-1:0]  window_length;
        logic             wake_request;
        logic             decided;
    } result_item_t;

endpackage

// ----- rtl/core/wicg_decide.sv -----
// Per-tick debounce and gating decision: next state and result from current state and item.
module wicg_decide (
    input  wicg_pkg::tick_item_t   item,
    input  wicg_pkg::gate_state_t  state,
    input  wicg_pkg::cfg_t         cfg,
    output wicg_pkg::gate_state_t  state_next,
    output wicg_pkg::result_item_t result
);
    import wicg_pkg::*;

    logic [TimeW-1:0] now;
    logic [TimeW-1:0] edge_t;
    logic [TimeW-1:0] since_edge;
    logic [TimeW-1:0] since_wake;
    logic             armed;
    logic             fire;
    logic             in_cooldown;
    logic             wake;

    always_comb begin
        now         = state.tick_clock;
        edge_t      = item.edge_seen ? now : state.edge_time;
        armed       = item.edge_seen | state.debounce_armed;
        since_edge  = now - edge_t;
        since_wake  = now - state.wake_time;
        fire        = armed && (since_edge >= {{(TimeW-CfgW){1'b0}}, cfg.debounce_ms});
        // A stored wake time of zero means no wake yet, so no lockout applies.
        in_cooldown = (state.wake_time != '0) &&
                      (since_wake < {{(TimeW-CfgW){1'b0}}, cfg.cooldown_ms});
        wake        = 1'b0;

        state_next                 = state;
        state_next.tick_clock      = now + 32'd1;
        state_next.edge_time       = edge_t;
        state_next.debounce_armed  = armed & ~fire;
        if (item.edge_seen) begin
            state_next.request_counter = state.request_counter + 32'd1;
        end

        if (fire) begin
            state_next.event_stamp = now;
            if (!item.pin_low) begin
                state_next.last_code = CODE_DEBOUNCE;
            end else if (in_cooldown) begin
                state_next.last_code = CODE_COOLDOWN;
            end else if (item.face_window_on) begin
                state_next.last_code = CODE_FACE;
            end else if (item.garage_recent) begin
                state_next.last_code = CODE_RECENT;
            end else if (!item.door_closed) begin
                state_next.last_code = CODE_DOOR;
            end else begin
                wake                      = 1'b1;
                state_next.last_code      = CODE_ACCEPT;
                state_next.wake_time      = now;
                state_next.accept_counter = state.accept_counter + 32'd1;
            end
        end

        result.decided        = fire;
        result.wake_request   = wake;
        result.window_length  = wake ? cfg.wake_window_ms : '0;
        result.result_code    = state_next.last_code;
        result.requests_total = state_next.request_counter;
        result.accepted_total = state_next.accept_counter;
        result.event_time     = state_next.event_stamp;
    end

endmodule

// ----- rtl/core/wake_input_debounce_cooldown_gate.sv -----
// Top level of the wake input debounce gate with cooldown lockout.
//
//  Channel   Direction  Payload (lowest bit first)                           Handshake
//  s_        in         edge_seen, pin_low, face_window_on, garage_recent,   tvalid/tready
//                       door_closed, 3 zero bits
//  m_        out        decided, wake_request, window_length[16],            tvalid/tready
//                       result_code[3], requests_total[32],
//                       accepted_total[32], event_time[32], 3 zero bits
//  cfg_      in         cfg_addr selects debounce, cooldown, window          cfg_we
//
// Every item is one tick and yields exactly one result item, in the cycle after
// it is accepted. The whole decision is one pass of compare and increment
// logic between the gate state registers and the result register, so one item
// is taken every cycle unless the output stalls. The input is ready whenever the
// result register is empty or being drained in the same cycle, so a stall on the
// result side holds back at most one item. Reset is synchronous and active low;
// it clears the tick clock, counters and gate state and loads the register defaults.
module wake_input_debounce_cooldown_gate (
    input  logic                                aclk,
    input  logic                                aresetn,
    // edge_seen, pin_low, face_window_on, garage_recent, door_closed, pad
    input  logic [wicg_pkg::InDataW-1:0]        s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // decided, wake_request, window_length, result_code, requests_total,
    // accepted_total, event_time, pad
    output logic [wicg_pkg::OutDataW-1:0]       m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_we,
    input  logic [wicg_pkg::CfgAddrW-1:0]       cfg_addr,
    input  logic [wicg_pkg::CfgW-1:0]           cfg_wdata
);
    import wicg_pkg::*;

    localparam int unsigned ResW = $bits(result_item_t);

    cfg_t         cfg_reg;
    gate_state_t  state_reg;
    gate_state_t  state_next;
    result_item_t result_next;
    result_item_t result_reg;
    logic         m_valid_reg;
    tick_item_t   item;
    logic         in_fire;

    assign item     = tick_item_t'(s_tdata[$bits(tick_item_t)-1:0]);
    assign s_tready = ~m_valid_reg | m_tready;
    assign in_fire  = s_tvalid & s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OutDataW-ResW){1'b0}}, result_reg};

    wicg_decide u_decide (
        .item       (item),
        .state      (state_reg),
        .cfg        (cfg_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Configuration registers; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms    <= DEBOUNCE_RST;
            cfg_reg.cooldown_ms    <= COOLDOWN_RST;
            cfg_reg.wake_window_ms <= WINDOW_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_DEBOUNCE: cfg_reg.debounce_ms    <= cfg_wdata;
                REG_COOLDOWN: cfg_reg.cooldown_ms    <= cfg_wdata;
                REG_WINDOW:   cfg_reg.wake_window_ms <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // Gate state advances once per accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (in_fire) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    // The result payload needs no reset; it is only read with m_tvalid high.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            result_reg <= result_next;
        end
    end

    // A wake is only ever granted on a tick that made a decision.
    a_wake_needs_decision: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (!result_reg.wake_request || result_reg.decided))
        else $error("wake granted without a debounced decision");

    // Each accepted tick yields a result in the next cycle.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> m_valid_reg)
        else $error("accepted item produced no result");

    // The tick clock moves by exactly one per accepted item.
    a_tick_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg.tick_clock == $past(state_reg.tick_clock) + 32'd1))
        else $error("tick clock did not advance by one");

    // The accept counter moves only together with a granted wake.
    a_accept_count: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg.accept_counter ==
                     $past(state_reg.accept_counter) + {31'd0, result_reg.wake_request}))
        else $error("accept counter out of step with wake grants");

    // A granted wake always reports the accepted code.
    a_wake_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && result_reg.wake_request) |-> (result_reg.result_code == CODE_ACCEPT))
        else $error("wake granted with wrong result code");

endmodule

// ----- tb/wake_input_debounce_cooldown_gate_tb.sv -----
// Self-checking testbench for the wake input debounce gate with cooldown lockout.
`timescale 1ns / 100ps

module wake_input_debounce_cooldown_gate_tb;

    import wicg_pkg::*;

    // The run is stopped as failed if it goes on longer than this.
    localparam int unsigned RUN_LIMIT = 400000;

    // Cycles the receiver holds off when a long hold is asked for.
    localparam int unsigned LONG_HOLD = 200;

    // There are only three registers, so index 3 has no register behind it
    // and a write there must be ignored.
    localparam logic [CfgAddrW-1:0] REG_SPARE = 2'd3;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic [InDataW-1:0]  s_tdata   = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [OutDataW-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [CfgAddrW-1:0] cfg_addr  = '0;
    logic [CfgW-1:0]     cfg_wdata = '0;

    // Tick items waiting to be offered, and the results predicted for the
    // items the block has already taken, oldest first.
    tick_item_t   tick_queue[$];
    result_item_t gate_results_due[$];

    // Our own copy of the gate: register settings and state.
    logic [CfgW-1:0]  deb_ms, cool_ms, win_ms;
    logic [TimeW-1:0] tick_now, edge_tick, wake_tick, stamp_tick;
    logic [TimeW-1:0] req_count, acc_count;
    logic             armed;
    result_code_t     code_now;

    // Idling control. Both sides idle in random bursts while idle_on is set.
    bit          idle_on = 1'b1;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    int unsigned hold_left = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_started = 0;

    int unsigned mismatches = 0;
    int unsigned failures = 0;
    int unsigned cycle_count = 0;

    wake_input_debounce_cooldown_gate dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Works out the result of one tick taken by the block. The tick number is
    // the count of items taken since reset. An edge restarts the debounce wait;
    // once the wait is over the gate checks, in priority order, the pin, the
    // cooldown since the last wake, the face window, a recent garage trigger
    // and the door. A stored wake time of zero stands for "never woke", so it
    // skips the cooldown check.
    task automatic gate_predict(input tick_item_t t);
        result_item_t     r;
        logic [TimeW-1:0] now;
        logic [TimeW-1:0] since_edge;
        logic [TimeW-1:0] since_wake;
        now = tick_now;
        r = '0;
        if (t.edge_seen) begin
            req_count = req_count + 1;
            edge_tick = now;
            armed = 1'b1;
        end
        since_edge = now - edge_tick;
        since_wake = now - wake_tick;
        if (armed && since_edge >= {16'd0, deb_ms}) begin
            armed = 1'b0;
            stamp_tick = now;
            r.decided = 1'b1;
            if (!t.pin_low) begin
                code_now = CODE_DEBOUNCE;
            end else if (wake_tick != '0 && since_wake < {16'd0, cool_ms}) begin
                code_now = CODE_COOLDOWN;
            end else if (t.face_window_on) begin
                code_now = CODE_FACE;
            end else if (t.garage_recent) begin
                code_now = CODE_RECENT;
            end else if (!t.door_closed) begin
                code_now = CODE_DOOR;
            end else begin
                wake_tick = now;
                acc_count = acc_count + 1;
                code_now = CODE_ACCEPT;
                r.wake_request = 1'b1;
                r.window_length = win_ms;
            end
        end
        tick_now = now + 1;
        r.result_code = code_now;
        r.requests_total = req_count;
        r.accepted_total = acc_count;
        r.event_time = stamp_tick;
        gate_results_due.push_back(r);
    endtask

    // Sender side. The item on the bus stays until it is taken; after that the
    // next one is offered unless a random idle burst starts. Every taken item
    // goes straight through the prediction. Register writes are tracked here
    // too, at the edge where the block sees them.
    always @(posedge aclk) begin : sender
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            send_gap   <= 0;
            deb_ms     = DEBOUNCE_RST;
            cool_ms    = COOLDOWN_RST;
            win_ms     = WINDOW_RST;
            tick_now   = '0;
            edge_tick  = '0;
            wake_tick  = '0;
            stamp_tick = '0;
            req_count  = '0;
            acc_count  = '0;
            armed      = 1'b0;
            code_now   = CODE_NONE;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_DEBOUNCE: begin
                        deb_ms = cfg_wdata;
                    end
                    REG_COOLDOWN: begin
                        cool_ms = cfg_wdata;
                    end
                    REG_WINDOW: begin
                        win_ms = cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                gate_predict(tick_item_t'(s_tdata[4:0]));
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 11) == 0) begin
                    // Starts a random idle burst; send_gap holds the rest of its length.
                    send_gap <= $urandom_range(0, 18);
                    s_tvalid <= 1'b0;
                end else if (tick_queue.size() > 0) begin
                    s_tdata  <= {3'b000, tick_queue.pop_front()};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver side. Each result taken is checked against the oldest
    // prediction. Ready drops in random stall bursts, and for one long stretch
    // whenever the stimulus asks for it, so the block has to stall its input.
    always @(posedge aclk) begin : receiver
        result_item_t got;
        result_item_t want;
        bit           bad;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            recv_stall <= 0;
            hold_left  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_item_t'(m_tdata[116:0]);
                if (gate_results_due.size() == 0) begin
                    failures++;
                    if (mismatches < 10) begin
                        $display("unexpected result item: code=%0d req=%0d event=%0d",
                                 got.result_code, got.requests_total, got.event_time);
                    end
                    mismatches++;
                end else begin
                    want = gate_results_due.pop_front();
                    bad = (got.decided !== want.decided)
                       || (got.wake_request !== want.wake_request)
                       || (got.window_length !== want.window_length)
                       || (got.result_code !== want.result_code)
                       || (got.requests_total !== want.requests_total)
                       || (got.accepted_total !== want.accepted_total)
                       || (got.event_time !== want.event_time);
                    if (bad) begin
                        failures++;
                        if (mismatches < 10) begin
                            $display("mismatch expected: dec=%0d wake=%0d win=%0d code=%0d",
                                     want.decided, want.wake_request, want.window_length,
                                     want.result_code);
                            $display("                   req=%0d acc=%0d event=%0d",
                                     want.requests_total, want.accepted_total,
                                     want.event_time);
                            $display("mismatch actual:   dec=%0d wake=%0d win=%0d code=%0d",
                                     got.decided, got.wake_request, got.window_length,
                                     got.result_code);
                            $display("                   req=%0d acc=%0d event=%0d",
                                     got.requests_total, got.accepted_total,
                                     got.event_time);
                        end
                        mismatches++;
                    end
                end
            end
            if (hold_requests != holds_started) begin
                holds_started <= holds_started + 1;
                hold_left <= LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 11) == 0) begin
                recv_stall <= $urandom_range(0, 18);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Writes one register. The block is idle whenever this is called.
    task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgW-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_gate(input logic [CfgW-1:0] deb, input logic [CfgW-1:0] cool,
                            input logic [CfgW-1:0] win);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_COOLDOWN, cool);
        write_reg(REG_WINDOW, win);
    endtask

    // Waits until every queued item was taken and every predicted result came.
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (tick_queue.size() != 0 || s_tvalid || gate_results_due.size() != 0);
    endtask

    task automatic push_tick(input logic e, input logic p, input logic f, input logic g,
                             input logic c);
        tick_item_t t;
        t.edge_seen      = e;
        t.pin_low        = p;
        t.face_window_on = f;
        t.garage_recent  = g;
        t.door_closed    = c;
        tick_queue.push_back(t);
    endtask

    // A tick whose gating inputs lean toward a wake being accepted, so that
    // most decisions get past the early checks.
    function automatic tick_item_t shaped_tick(input logic e);
        tick_item_t t;
        t.edge_seen      = e;
        t.pin_low        = ($urandom_range(0, 9) != 0);
        t.face_window_on = ($urandom_range(0, 6) == 0);
        t.garage_recent  = ($urandom_range(0, 6) == 0);
        t.door_closed    = ($urandom_range(0, 6) != 0);
        return t;
    endfunction

    // Queues about count ticks, mostly as an edge and a quiet stretch that, for deb
    // of at most 60, usually runs past the debounce wait, with random ticks as noise.
    task automatic add_bursts(input int unsigned deb, input int unsigned count);
        int unsigned n;
        int unsigned quiet;
        n = 0;
        while (n < count) begin
            if ($urandom_range(0, 4) == 0) begin
                tick_queue.push_back(tick_item_t'(5'($urandom_range(0, 31))));
                n++;
            end else begin
                tick_queue.push_back(shaped_tick(1'b1));
                n++;
                if (deb > 60) begin
                    quiet = $urandom_range(0, 20);
                end else if ($urandom_range(0, 3) == 0) begin
                    quiet = $urandom_range(0, deb);
                end else begin
                    quiet = deb + $urandom_range(0, 2);
                end
                repeat (quiet) begin
                    tick_queue.push_back(shaped_tick($urandom_range(0, 39) == 0));
                    n++;
                end
            end
        end
    endtask

    initial begin : watchdog
        while (cycle_count < RUN_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        logic [CfgW-1:0] deb;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. With no debounce each edge is decided on its own tick.
        // The very first tick is accepted at tick zero, which stores a wake time
        // of zero, so the next tick is accepted as well without any cooldown.
        set_gate(16'd0, 16'd5, 16'hFFFF);
        write_reg(REG_SPARE, 16'hFFFF);
        push_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
        push_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
        // Inside the cooldown now, then a pin that went high again.
        push_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
        push_tick(1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
        push_tick(1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
        push_tick(1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        // Cooldown just over: face, garage and door each block the wake alone.
        push_tick(1'b1, 1'b1, 1'b1, 1'b0, 1'b1);
        push_tick(1'b1, 1'b1, 1'b0, 1'b1, 1'b1);
        push_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
        // The pin check wins over everything, the face check over the rest.
        push_tick(1'b1, 1'b0, 1'b1, 1'b1, 1'b0);
        push_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        push_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
        // The cooldown check wins over face, garage and door.
        push_tick(1'b1, 1'b1, 1'b1, 1'b1, 1'b0);
        wait_drained();

        // Another edge inside the wait restarts it.
        set_gate(16'd3, 16'd5, 16'd0);
        push_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
        push_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
        push_tick(1'b1, 1'b1, 1'b0, 1'b0, 1'b1);
        push_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
        push_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
        push_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
        push_tick(1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
        wait_drained();

        // Random part: a range of settings, the extremes among them.
        set_gate(16'd0, 16'd0, 16'd1);
        add_bursts(0, 100);
        wait_drained();

        // Halfway through, the sender waits until every result is back.
        set_gate(16'd1, 16'd7, 16'($urandom));
        add_bursts(1, 50);
        wait_drained();
        add_bursts(1, 50);
        wait_drained();

        // The receiver holds off for a long stretch while items keep coming.
        deb = 16'($urandom_range(2, 6));
        set_gate(deb, 16'($urandom_range(10, 40)), 16'($urandom));
        hold_requests++;
        add_bursts(deb, 100);
        wait_drained();

        // The longest wait: edges only arm it, no decision is made here.
        set_gate(16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_bursts(16'hFFFF, 40);
        wait_drained();

        // The still armed wait ends at once; after a wake the cooldown never ends.
        set_gate(16'd0, 16'hFFFF, 16'hA5A5);
        add_bursts(0, 80);
        wait_drained();

        // Back to the reset settings.
        set_gate(DEBOUNCE_RST, COOLDOWN_RST, WINDOW_RST);
        add_bursts(50, 120);
        wait_drained();

        // Last part at full rate on both sides.
        idle_on = 1'b0;
        deb = 16'($urandom_range(0, 4));
        set_gate(deb, 16'($urandom_range(0, 30)), 16'($urandom));
        add_bursts(deb, 200);
        wait_drained();

        // An extra wait afterwards catches any stray result.
        repeat (5) @(negedge aclk);
        if (gate_results_due.size() != 0) begin
            failures++;
        end
        if (failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
